/* sv/timed_output_event_scheduler_defines.svh */
// ----------------------------------------------------------------------------
// Timed output event scheduler: assertion macros
// Shared macros for the concurrent checks of the scheduler.
// ----------------------------------------------------------------------------
`ifndef TIMED_OUTPUT_EVENT_SCHEDULER_DEFINES_SVH
`define TIMED_OUTPUT_EVENT_SCHEDULER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define TOES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define TOES_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* sv/toes_pkg.sv */
// ----------------------------------------------------------------------------
// Timed output event scheduler package
// Item, result and queue entry types shared by the scheduler files.
// ----------------------------------------------------------------------------
package toes_pkg;

  localparam int TIME_W  = 48;
  localparam int VALUE_W = 32;
  localparam int PEND_W  = 5;

  localparam logic KIND_SCHEDULE = 1'b0;
  localparam logic KIND_TICK     = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [TIME_W-1:0]  event_time;
    logic [VALUE_W-1:0] event_value;
    logic [TIME_W-1:0]  now;
  } item_t;

  typedef struct packed {
    logic               fired;
    logic [VALUE_W-1:0] fired_value;
    logic               dropped;
    logic [PEND_W-1:0]  pending_count;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0]  due_time;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

/* sv/toes_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module toes_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/timed_output_event_scheduler.sv */
// ----------------------------------------------------------------------------
// Timed output event scheduler
// Time-ordered queue of scheduled port writes with tick-driven release.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its single result
// appears for one cycle on the result port with done high and cannot be held
// off. The queue lives in one RAM used as a ring between head and tail
// pointers. A tick into an empty queue, or a schedule into an empty or full
// queue, is answered directly from idle and leaves busy low. A tick into a
// non-empty queue first reads the head. A schedule into a non-empty queue walks
// back from the tail through the RAM read port, one entry per cycle, moving
// later entries up by one until the new entry's place is found. The walk
// shares the single RAM read port and one comparator.
module timed_output_event_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  toes_pkg::item_t  item,
  output logic             done,
  output toes_pkg::result_t result
);

  import toes_pkg::*;

  `include "timed_output_event_scheduler_defines.svh"

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = TIME_W + VALUE_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HEAD  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_PLACE = 4'b1000
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [PW-1:0]      head, head_next;
  logic [PW-1:0]      tail, tail_next;
  logic [PW-1:0]      cur, cur_next;
  logic [PW-1:0]      lpos, lpos_next;
  logic [TIME_W-1:0]  key, key_next;
  logic [VALUE_W-1:0] val, val_next;
  logic               done_next;
  result_t            result_next;

  logic               ram_we;
  logic [PW-1:0]      ram_waddr;
  logic [PW-1:0]      ram_raddr;
  entry_t             ram_wdata;
  entry_t             ram_rdata;
  logic [EW-1:0]      ram_rbits;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  toes_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  assign ram_rdata = entry_t'(ram_rbits);
  assign busy      = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    count_next  = count;
    head_next   = head;
    tail_next   = tail;
    cur_next    = cur;
    lpos_next   = lpos;
    key_next    = key;
    val_next    = val;
    done_next   = 1'b0;
    result_next = '0;
    ram_we      = 1'b0;
    ram_waddr   = cur;
    ram_wdata   = '{due_time: key, value: val};
    ram_raddr   = cur;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          val_next = item.event_value;
          if (item.kind == KIND_TICK) begin
            key_next = item.now;
            if (count == '0) begin
              done_next = 1'b1;
            end else begin
              ram_raddr  = head;
              state_next = S_HEAD;
            end
          end else begin
            key_next = item.event_time;
            if (count == CW'(QUEUE_DEPTH)) begin
              done_next           = 1'b1;
              result_next.dropped = 1'b1;
            end else if (count == '0) begin
              ram_we     = 1'b1;
              ram_waddr  = tail;
              ram_wdata  = '{due_time: item.event_time, value: item.event_value};
              tail_next  = ptr_inc(tail);
              count_next = count + 1'b1;
              done_next  = 1'b1;
            end else begin
              // Start the walk at the last stored entry.
              ram_raddr  = ptr_dec(tail);
              cur_next   = ptr_dec(tail);
              lpos_next  = PW'(count - 1'b1);
              state_next = S_SHIFT;
            end
          end
        end
      end

      S_HEAD: begin
        if (key > ram_rdata.due_time) begin
          result_next.fired       = 1'b1;
          result_next.fired_value = ram_rdata.value;
          head_next               = ptr_inc(head);
          count_next              = count - 1'b1;
        end
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      S_SHIFT: begin
        if (ram_rdata.due_time > key) begin
          // Later entry moves up one slot to open a gap.
          ram_we    = 1'b1;
          ram_waddr = ptr_inc(cur);
          ram_wdata = ram_rdata;
          if (lpos == '0) begin
            state_next = S_PLACE;
          end else begin
            ram_raddr = ptr_dec(cur);
            cur_next  = ptr_dec(cur);
            lpos_next = lpos - 1'b1;
          end
        end else begin
          // Equal times stay in arrival order: the new entry goes behind.
          ram_we     = 1'b1;
          ram_waddr  = ptr_inc(cur);
          tail_next  = ptr_inc(tail);
          count_next = count + 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_PLACE: begin
        ram_we     = 1'b1;
        ram_waddr  = cur;
        tail_next  = ptr_inc(tail);
        count_next = count + 1'b1;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    result_next.pending_count = PEND_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      head  <= '0;
      tail  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      head  <= head_next;
      tail  <= tail_next;
      done  <= done_next;
    end
    cur    <= cur_next;
    lpos   <= lpos_next;
    key    <= key_next;
    val    <= val_next;
    result <= result_next;
  end

  `TOES_ASSERT(a_count_bound, count <= CW'(QUEUE_DEPTH), "entry count above queue depth")
  `TOES_ASSERT(a_done_idle, done |-> !busy, "result shown while still busy")
  `TOES_ASSERT(a_accept_progress, (start && !busy) |=> (busy || done), "transfer made no progress")
  `TOES_ASSERT_NEVER(a_fire_drop, done && result.fired && result.dropped, "fired and dropped together")
  `TOES_ASSERT(a_ring_empty, (count == '0) |-> (head == tail), "empty queue with split pointers")

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Timed output event scheduler testbench
// Sends schedule and tick items through the start/busy port, predicts each
// result with a time-ordered queue of its own and checks every done strobe
// against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import toes_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int RUN_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4 * QUEUE_DEPTH;
  localparam int PHASE_ITEMS = 340;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct {
    item_t       payload;
    int unsigned idle_pct;
    bit          drain_first;
  } send_slot_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    done;
  result_t result;

  timed_output_event_scheduler #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk, .rst, .start, .busy, .item, .done, .result
  );

  always #4 clk = ~clk;

  send_slot_t  send_queue[$];
  send_slot_t  next_slot;
  result_t     predicted_results[$];
  result_t     oldest_result;
  logic        took_item = 1'b0;
  logic        all_settled = 1'b0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Stimulus shaping state.
  int unsigned        phase_idle = 32;
  bit                 drain_next = 1'b0;
  int unsigned        queued_total = 0;
  logic [TIME_W-1:0]  stim_now = 48'd1000;
  logic [TIME_W-1:0]  last_sched_time = '0;

  // Predicted contents of the scheduler queue, head at index 0.
  entry_t      sched_entries[QUEUE_DEPTH];
  int unsigned sched_count = 0;

  function automatic result_t advance_schedule(item_t it);
    result_t r;
    int      pos;
    r = '0;
    if (it.kind == KIND_SCHEDULE) begin
      if (sched_count >= QUEUE_DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        // Equal times stay in arrival order, so walk past every entry <= the new time.
        pos = 0;
        while (pos < int'(sched_count) && sched_entries[pos].due_time <= it.event_time) pos++;
        for (int k = int'(sched_count); k > pos; k--) sched_entries[k] = sched_entries[k-1];
        sched_entries[pos] = '{due_time: it.event_time, value: it.event_value};
        sched_count++;
      end
    end else if (sched_count != 0 && it.now > sched_entries[0].due_time) begin
      r.fired = 1'b1;
      r.fired_value = sched_entries[0].value;
      for (int k = 1; k < int'(sched_count); k++) sched_entries[k-1] = sched_entries[k];
      sched_count--;
    end
    r.pending_count = PEND_W'(sched_count);
    return r;
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      error_count++;
    end
  endtask

  function automatic logic [TIME_W-1:0] random_time();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // The field a kind does not use is filled at random all the same.
  task automatic queue_schedule(logic [TIME_W-1:0] t, logic [VALUE_W-1:0] v);
    send_slot_t s;
    s.payload = '{kind: KIND_SCHEDULE, event_time: t, event_value: v, now: random_time()};
    s.idle_pct = phase_idle;
    s.drain_first = drain_next;
    drain_next = 1'b0;
    send_queue.push_back(s);
    queued_total++;
    last_sched_time = t;
  endtask

  task automatic queue_tick(logic [TIME_W-1:0] t);
    send_slot_t s;
    s.payload = '{kind: KIND_TICK, event_time: random_time(), event_value: $urandom, now: t};
    s.idle_pct = phase_idle;
    s.drain_first = drain_next;
    drain_next = 1'b0;
    send_queue.push_back(s);
    queued_total++;
  endtask

  task automatic queue_random_phase(int unsigned count);
    int unsigned target;
    int unsigned burst;
    target = queued_total + count;
    while (queued_total < target) begin
      burst = $urandom_range(99);
      if (burst < 35) begin
        repeat ($urandom_range(4, 1)) begin
          if ($urandom_range(3) == 0) queue_schedule(last_sched_time, random_value());
          else queue_schedule(stim_now + TIME_W'($urandom_range(300)), random_value());
        end
      end else if (burst < 80) begin
        repeat ($urandom_range(8, 1)) begin
          stim_now = stim_now + TIME_W'($urandom_range(120));
          case ($urandom_range(9))
            0: queue_tick(last_sched_time);
            1: queue_tick(last_sched_time + 1);
            default: queue_tick(stim_now);
          endcase
        end
      end else if (burst < 88) begin
        // A burst of schedules that can fill the queue and lose some.
        repeat ($urandom_range(18, 10)) begin
          queue_schedule(stim_now + TIME_W'($urandom_range(40)), $urandom);
        end
      end else begin
        case ($urandom_range(7))
          0: queue_tick(TIME_MAX);
          1, 2, 3: queue_tick(random_time());
          default: queue_schedule(random_time(), random_value());
        endcase
      end
    end
  endtask

  // Driver: a new item is presented only after the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took_item) begin
      if (send_queue.size() != 0 &&
          !(send_queue[0].drain_first && predicted_results.size() != 0) &&
          $urandom_range(99) >= send_queue[0].idle_pct) begin
        next_slot = send_queue.pop_front();
        item <= next_slot.payload;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor and predictor.
  always @(posedge clk) begin
    if (rst) begin
      took_item <= 1'b0;
      all_settled <= 1'b0;
    end else begin
      took_item <= start && !busy;
      if (done) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, result);
          error_count++;
        end else begin
          oldest_result = predicted_results.pop_front();
          check_field("fired", 64'(oldest_result.fired), 64'(result.fired));
          check_field("fired_value", 64'(oldest_result.fired_value), 64'(result.fired_value));
          check_field("dropped", 64'(oldest_result.dropped), 64'(result.dropped));
          check_field("pending_count", 64'(oldest_result.pending_count),
                      64'(result.pending_count));
        end
      end
      if (start && !busy) predicted_results.push_back(advance_schedule(item));
      all_settled <= send_queue.size() == 0 && !start && predicted_results.size() == 0;
    end
  end

  initial begin
    // Ticks on an empty queue, at both ends of time.
    queue_tick('0);
    queue_tick(TIME_MAX);
    // A tick equal to the head's time holds it; one time unit later fires it.
    queue_schedule('0, '0);
    queue_tick('0);
    queue_tick(48'd1);
    // This entry can never fire and stays at the tail for the whole run.
    queue_schedule(TIME_MAX, '1);
    // Fill with ties so arrival order among equal times is visible.
    for (int k = 0; k < QUEUE_DEPTH - 1; k++) queue_schedule(48'((k % 3) * 5), 32'h100 + k);
    queue_schedule('0, '1);
    queue_tick(TIME_MAX);
    queue_tick('0);

    queue_random_phase(PHASE_ITEMS);
    phase_idle = 46;
    drain_next = 1'b1;
    queue_random_phase(PHASE_ITEMS);
    phase_idle = 0;
    drain_next = 1'b1;
    queue_random_phase(PHASE_ITEMS);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (!all_settled) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run limit reached, %0d results outstanding", $time,
             predicted_results.size());
    $display("tb: failure");
    $finish;
  end

endmodule
